>>> rtl/core/ced_pkg.sv
// Package for the CSS escape stream decoder: result and queue entry types,
// scan mode encoding, byte constants and the hex digit helper functions.
// Depends on nothing; the front end, queue, back end and top level import it.
`timescale 1ns / 1ps

package ced_pkg;

  localparam int MAX_HEX_DIGITS = 6;
  localparam int HEX_CNT_W      = 3;
  localparam int HEX_NIB_W      = 4 * MAX_HEX_DIGITS;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_AW       = 2;

  localparam logic [7:0] CHAR_BSLASH      = 8'h5C;
  localparam logic [7:0] CHAR_NEWLINE     = 8'h0A;
  localparam logic [7:0] CHAR_SPACE       = 8'h20;
  localparam logic [7:0] FULLWIDTH_LIMIT  = 8'h5F;
  localparam logic [7:0] FULLWIDTH_OFFSET = 8'h20;
  localparam logic [3:0] NIBBLE_F         = 4'hF;

  // One-hot scan mode.
  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_BSLASH = 4'b0010,
    MODE_HEX    = 4'b0100,
    MODE_SKIPWS = 4'b1000
  } ced_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       changed;
  } ced_result_t;

  // One queue entry holds all results of one input byte (one or two).
  typedef struct packed {
    logic        two;
    ced_result_t r0;
    ced_result_t r1;
  } ced_entry_t;

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66);
  endfunction

  // Valid only for hex digits: letters sit at 1..6 in their low nibble.
  function automatic logic [3:0] hex_val(input logic [7:0] b);
    return b[6] ? (b[3:0] + 4'd9) : b[3:0];
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CHAR_SPACE) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  // Value of a finished hex escape, with the full-width ASCII fold.
  function automatic logic [7:0] hex_decode(input logic [HEX_CNT_W-1:0] c,
                                            input logic [HEX_NIB_W-1:0] n);
    logic [7:0] v;
    logic       full;
    v    = n[7:0];
    full = 1'b0;
    if (c <= HEX_CNT_W'(1)) begin
      v = {4'd0, n[3:0]};
    end else begin
      if (c == HEX_CNT_W'(4)) full = 1'b1;
      else if (c == HEX_CNT_W'(5)) full = (n[19:16] == 4'd0);
      else if (c == HEX_CNT_W'(6)) full = (n[23:16] == 8'd0);
      if (full && v != 8'd0 && v < FULLWIDTH_LIMIT &&
          n[11:8] == NIBBLE_F && n[15:12] == NIBBLE_F) begin
        v = v + FULLWIDTH_OFFSET;
      end
    end
    return v;
  endfunction

endpackage

>>> rtl/core/ced_front.sv
// Front end of the CSS escape stream decoder: escape state machine that
// writes the results of an accepted byte, up to two, as one queue entry.
// Depends on ced_pkg.
`timescale 1ns / 1ps

module ced_front import ced_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] byte_data,
  input  logic       byte_last,
  input  logic       q_full,
  output logic       q_push,
  output ced_entry_t q_entry
);

  ced_mode_t              mode, mode_next;
  logic [HEX_CNT_W-1:0]   hex_count, hex_count_next;
  logic [HEX_NIB_W-1:0]   hex_nibbles, hex_nibbles_next;
  logic                   changed_seen, changed_seen_next;

  logic                   digit, space, add_digit, flush_en, plain_call, direct_en;
  logic [HEX_CNT_W-1:0]   acc_cnt, dec_cnt;
  logic [HEX_NIB_W-1:0]   acc_nib, dec_nib;
  logic [7:0]             flush_byte;
  logic                   accept;

  assign accept     = byte_valid && !q_full;
  assign byte_ready = !q_full;
  assign digit      = is_hex(byte_data);
  assign space      = is_space(byte_data);

  // A digit right after the backslash starts a fresh accumulation.
  assign acc_nib = (mode == MODE_BSLASH) ? {{(HEX_NIB_W-4){1'b0}}, hex_val(byte_data)}
                                         : {hex_nibbles[HEX_NIB_W-5:0], hex_val(byte_data)};
  assign acc_cnt = (mode == MODE_BSLASH) ? HEX_CNT_W'(1) : hex_count + HEX_CNT_W'(1);

  always_comb begin
    mode_next         = mode;
    hex_count_next    = hex_count;
    hex_nibbles_next  = hex_nibbles;
    changed_seen_next = changed_seen;
    add_digit         = 1'b0;
    flush_en          = 1'b0;
    plain_call        = 1'b0;
    direct_en         = 1'b0;

    case (mode)
      MODE_BSLASH: begin
        if (digit) begin
          add_digit = 1'b1;
        end else if (byte_data == CHAR_NEWLINE) begin
          changed_seen_next = 1'b1;
          mode_next         = MODE_NORMAL;
        end else begin
          direct_en = 1'b1;
          mode_next = MODE_NORMAL;
        end
      end
      MODE_HEX: begin
        if (digit) begin
          add_digit = 1'b1;
        end else begin
          flush_en   = 1'b1;
          mode_next  = MODE_NORMAL;
          plain_call = !space;
        end
      end
      MODE_SKIPWS: begin
        mode_next  = MODE_NORMAL;
        plain_call = !space;
      end
      default: begin
        plain_call = 1'b1;
      end
    endcase

    if (add_digit) begin
      hex_nibbles_next = acc_nib;
      hex_count_next   = acc_cnt;
      mode_next        = MODE_HEX;
      if (acc_cnt >= HEX_CNT_W'(MAX_HEX_DIGITS)) begin
        flush_en  = 1'b1;
        mode_next = MODE_SKIPWS;
      end else if (byte_last) begin
        flush_en  = 1'b1;
        mode_next = MODE_NORMAL;
      end
    end

    if (plain_call) begin
      if (byte_data == CHAR_BSLASH) begin
        if (byte_last) begin
          changed_seen_next = 1'b1;
          mode_next         = MODE_NORMAL;
        end else begin
          mode_next = MODE_BSLASH;
        end
      end else begin
        direct_en = 1'b1;
        mode_next = MODE_NORMAL;
      end
    end

    if (flush_en) begin
      changed_seen_next = 1'b1;
      hex_count_next    = '0;
      hex_nibbles_next  = '0;
    end
  end

  assign dec_cnt    = add_digit ? acc_cnt : hex_count;
  assign dec_nib    = add_digit ? acc_nib : hex_nibbles;
  assign flush_byte = hex_decode(dec_cnt, dec_nib);

  // The decoded escape byte always precedes the byte that ended it.
  always_comb begin
    q_entry.two        = flush_en && direct_en;
    q_entry.r0.data    = flush_en ? flush_byte : (direct_en ? byte_data : 8'd0);
    q_entry.r0.valid   = flush_en || direct_en;
    q_entry.r0.last    = byte_last && !q_entry.two;
    q_entry.r0.changed = byte_last && !q_entry.two && changed_seen_next;
    q_entry.r1.data    = byte_data;
    q_entry.r1.valid   = 1'b1;
    q_entry.r1.last    = byte_last;
    q_entry.r1.changed = byte_last && changed_seen_next;
  end

  assign q_push = accept && (flush_en || direct_en || byte_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_NORMAL;
      hex_count    <= '0;
      hex_nibbles  <= '0;
      changed_seen <= 1'b0;
    end else if (accept) begin
      if (byte_last) begin
        mode         <= MODE_NORMAL;
        hex_count    <= '0;
        hex_nibbles  <= '0;
        changed_seen <= 1'b0;
      end else begin
        mode         <= mode_next;
        hex_count    <= hex_count_next;
        hex_nibbles  <= hex_nibbles_next;
        changed_seen <= changed_seen_next;
      end
    end
  end

endmodule

>>> rtl/core/ced_queue.sv
// Short entry queue between the front and back ends of the decoder.
// Depends on ced_pkg for the entry type and depth.
`timescale 1ns / 1ps

module ced_queue import ced_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  ced_entry_t push_entry,
  input  logic       pop,
  output ced_entry_t head,
  output logic       full,
  output logic       not_empty
);

  ced_entry_t            slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]     fill;

  assign full      = (fill == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QUEUE_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + QUEUE_AW'(1);
      case ({push, pop})
        2'b10:   fill <= fill + (QUEUE_AW+1)'(1);
        2'b01:   fill <= fill - (QUEUE_AW+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> rtl/core/ced_back.sv
// Back end of the decoder: takes queue entries and hands their results out
// one transfer at a time from a registered output stage. Depends on ced_pkg.
`timescale 1ns / 1ps

module ced_back import ced_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  ced_entry_t q_head,
  output logic       q_pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast,
  output logic [1:0] m_tuser
);

  ced_entry_t  hold;
  logic        hold_valid;
  logic        phase;
  logic        xfer, finishing;
  ced_result_t cur;

  assign cur       = phase ? hold.r1 : hold.r0;
  assign xfer      = hold_valid && m_tready;
  assign finishing = xfer && (!hold.two || phase);
  assign q_pop     = q_valid && (!hold_valid || finishing);

  assign m_tvalid = hold_valid;
  assign m_tdata  = cur.data;
  assign m_tlast  = cur.last;
  assign m_tuser  = {cur.changed, cur.valid};

  always_ff @(posedge clk) begin
    if (q_pop) hold <= q_head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      phase      <= 1'b0;
    end else if (q_pop) begin
      hold_valid <= 1'b1;
      phase      <= 1'b0;
    end else if (finishing) begin
      hold_valid <= 1'b0;
      phase      <= 1'b0;
    end else if (xfer) begin
      phase <= 1'b1;
    end
  end

endmodule

>>> rtl/core/css_escape_stream_decoder.sv
// CSS escape stream decoder, top level. A result passes through a queue slot and
// then the back end's output register before it is offered on the output.
// Throughput: one input byte per cycle while the queue is not full; output is one
// result per cycle while the sink is ready, so a byte that yields two results
// (escape value plus the byte that ended it) takes two output transfers, absorbed
// by the four-entry queue. Reset (rst, synchronous, active high) clears the escape state and empties both ends.
`timescale 1ns / 1ps

module css_escape_stream_decoder import ced_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  // Input byte stream.
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // in_last: final byte of the string
  // Decoded result stream.
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // out_last: final result of the string
  output logic [1:0] m_tuser    // [0] out_valid, [1] changed
);

  // The front end runs the escape state machine, one byte per transfer, and
  // writes all results of that byte as a single queue entry. It stalls only
  // when the queue is full.
  logic       q_push, q_full, q_not_empty, q_pop;
  ced_entry_t q_in, q_head;

  ced_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (s_tvalid),
    .byte_ready (s_tready),
    .byte_data  (s_tdata),
    .byte_last  (s_tlast),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_in)
  );

  // The queue decouples the two sides so a stalled sink does not stop the
  // front end until the queue fills.
  ced_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .not_empty  (q_not_empty)
  );

  // The back end holds one entry in its output register and serializes its
  // results; the next entry is loaded in the same cycle the last one leaves.
  ced_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_not_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

>>> rtl/core/ced_checker.sv
// Port-level checker for the CSS escape stream decoder and its bind.
// Depends on ced_pkg only through the bound top level.
`timescale 1ns / 1ps

module ced_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic [1:0] m_tuser
);

  // Reset leaves no result on the output.
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered right after reset");

  // The change flag only rides on the final result of a string.
  a_changed_on_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> m_tlast)
    else $error("changed set on a result that is not last");

  // An empty result only closes a string, and carries a zero byte.
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tlast && m_tdata == 8'd0))
    else $error("empty result that is not a zero final result");

  // A stalled result holds.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=>
      (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
    else $error("output changed while stalled");

endmodule

bind css_escape_stream_decoder ced_checker u_ced_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
